FILE: design/lwd_pkg.sv
package lwd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int NUM_W         = 18;
  localparam int WSUM_W        = 10;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_W         = 16;
  localparam int IDX_W         = 3;
  localparam int IN_DATA_W     = 24;

  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;

  typedef struct packed {
    logic             drain;
    logic [NUM_W-1:0] num;
  } item_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_WRED   = 3'd2,
    REG_WGREEN = 3'd3,
    REG_WBLUE  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVX,
    ST_GREY,
    ST_DIVG,
    ST_SHIFT,
    ST_BLUR,
    ST_MUL,
    ST_RDIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic pop;
    logic div_start;
    logic mem_we;
    logic clearing;
  } ctrl_t;

endpackage

FILE: design/lwd_front.sv
module lwd_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  hold,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lwd_pkg::IN_DATA_W-1:0]         s_axis_tdata,  // red, green, blue
  input  logic                                  s_axis_tuser,  // action
  input  logic [lwd_pkg::PIX_W-1:0]             wred,
  input  logic [lwd_pkg::PIX_W-1:0]             wgreen,
  input  logic [lwd_pkg::PIX_W-1:0]             wblue,
  input  logic                                  q_ready,
  output logic                                  q_push,
  output lwd_pkg::item_t                        q_item
);

  logic           stg_valid;
  lwd_pkg::item_t stg_item;
  logic [lwd_pkg::NUM_W-1:0] num;

  assign num = lwd_pkg::NUM_W'(wred)   * lwd_pkg::NUM_W'(s_axis_tdata[7:0])
             + lwd_pkg::NUM_W'(wgreen) * lwd_pkg::NUM_W'(s_axis_tdata[15:8])
             + lwd_pkg::NUM_W'(wblue)  * lwd_pkg::NUM_W'(s_axis_tdata[23:16]);

  assign s_axis_tready = !hold && (!stg_valid || q_ready);
  assign q_push        = stg_valid && q_ready;
  assign q_item        = stg_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid <= s_axis_tvalid;
    end else if (q_push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stg_item.drain <= s_axis_tuser;
      stg_item.num   <= num;
    end
  end

endmodule

FILE: design/lwd_queue.sv
module lwd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lwd_pkg::item_t wr_item,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output lwd_pkg::item_t rd_item
);

  lwd_pkg::item_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;

  assign ready   = cnt != 2'd2;
  assign valid   = cnt != 2'd0;
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push && ready) begin
        wptr <= !wptr;
      end
      if (pop && valid) begin
        rptr <= !rptr;
      end
      cnt <= cnt + 2'(push && ready) - 2'(pop && valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push && ready) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

FILE: design/lwd_div.sv
module lwd_div #(
  parameter int NW = 27,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    q;
  logic [DW-1:0]    r;
  logic [DW-1:0]    dsr;
  logic [DW:0]      rsh;
  logic [DW:0]      diff;
  logic             ge;

  assign rsh  = {r, q[NW-1]};
  assign ge   = rsh >= {1'b0, dsr};
  assign diff = rsh - {1'b0, dsr};
  assign quot = q;
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
      done <= cnt == CNT_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      dsr <= divisor;
    end else if (busy) begin
      q <= {q[NW-2:0], ge};
      r <= ge ? diff[DW-1:0] : rsh[DW-1:0];
    end
  end

endmodule

FILE: design/lwd_back.sv
module lwd_back #(
  parameter int MAX_WIDTH = lwd_pkg::MAX_WIDTH_DEF,
  parameter int WW        = $clog2(MAX_WIDTH + 1),
  parameter int NW        = WW + 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [WW-1:0]                   width,
  input  logic [lwd_pkg::HEIGHT_W-1:0]    height,
  input  logic [NW-1:0]                   total,
  input  logic [lwd_pkg::WSUM_W-1:0]      wsum,
  input  logic                            q_valid,
  input  lwd_pkg::item_t                  q_item,
  output lwd_pkg::ctrl_t                  ctrl,
  output logic                            m_valid,
  input  logic                            m_ready,
  output logic [lwd_pkg::PIX_W-1:0]       m_pixel,
  output logic                            m_last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DV = (WW > lwd_pkg::WSUM_W) ? WW : lwd_pkg::WSUM_W;

  lwd_pkg::state_t state, state_next;

  logic [15:0]  mem [MAX_WIDTH];
  logic [15:0]  rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] clr_addr;

  logic [NW-1:0] items;
  logic [NW-1:0] sent;
  logic [NW-1:0] n;
  logic [NW-1:0] n_sel;
  logic [NW-1:0] qn;
  logic [NW-1:0] kp1;
  logic [AW-1:0] x;
  logic          drain;
  logic [lwd_pkg::NUM_W-1:0] num;
  logic [7:0]    v;
  logic [7:0]    win [9];
  logic          hu, hd, hl, hr, last;
  logic          need;
  logic          has;

  logic [7:0]    c, blur, rq;
  logic [9:0]    lapm;
  logic [17:0]   mag;
  logic          sgn;
  logic [31:0]   rprod;

  logic          div_done;
  logic [NW-1:0] div_a;
  logic [DV-1:0] div_b;
  logic [NW-1:0] div_q;
  logic [DV-1:0] div_r;

  logic          xz;
  logic [AW-1:0] cx;
  logic [NW-1:0] cyp;
  logic [9:0]    s4, dg;
  logic [11:0]   bsum;
  logic [10:0]   lap_s;
  logic [8:0]    diff;
  logic [7:0]    dmag;
  logic [7:0]    res;

  lwd_div #(.NW(NW), .DW(DV)) u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign n_sel = (sent >= total) ? '0 : items;
  assign need  = !drain && (n < total) && (wsum != '0);
  assign has   = (n >= NW'(width) + NW'(1)) && (n < total + NW'(width) + NW'(1));

  assign xz  = x == '0;
  assign cx  = xz ? AW'(width - WW'(1)) : x - AW'(1);
  assign cyp = xz ? qn - NW'(1) : qn;

  assign s4   = (hu ? 10'(win[1]) : 10'd0) + (hd ? 10'(win[7]) : 10'd0)
              + (hl ? 10'(win[3]) : 10'd0) + (hr ? 10'(win[5]) : 10'd0);
  assign dg   = ((hu && hl) ? 10'(win[0]) : 10'd0) + ((hu && hr) ? 10'(win[2]) : 10'd0)
              + ((hd && hl) ? 10'(win[6]) : 10'd0) + ((hd && hr) ? 10'(win[8]) : 10'd0);
  assign bsum  = {1'b0, s4, 1'b0} + 12'(dg) + 12'({win[4], 2'b00});
  assign lap_s = {1'b0, win[4], 2'b00} - {1'b0, s4};
  assign diff  = {1'b0, c} - {1'b0, blur};
  assign dmag  = diff[8] ? 8'(-diff) : diff[7:0];
  assign res   = sgn ? blur - rq : blur + rq;

  // divide by 1020 as a divide by 4, then by 255 through a reciprocal multiply
  assign rprod = 32'(mag[17:2]) * 32'(lwd_pkg::RECIP_255);

  always_comb begin
    div_a = n_sel;
    div_b = DV'(width);
    case (state)
      lwd_pkg::ST_GREY: begin
        div_a = NW'(num);
        div_b = DV'(wsum);
      end
      default: begin
        div_a = n_sel;
        div_b = DV'(width);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      lwd_pkg::ST_CLEAR: if (clr_addr == AW'(MAX_WIDTH - 1)) state_next = lwd_pkg::ST_IDLE;
      lwd_pkg::ST_IDLE:  if (q_valid) state_next = lwd_pkg::ST_DIVX;
      lwd_pkg::ST_DIVX:  if (div_done) state_next = lwd_pkg::ST_GREY;
      lwd_pkg::ST_GREY:  state_next = need ? lwd_pkg::ST_DIVG : lwd_pkg::ST_SHIFT;
      lwd_pkg::ST_DIVG:  if (div_done) state_next = lwd_pkg::ST_SHIFT;
      lwd_pkg::ST_SHIFT: state_next = has ? lwd_pkg::ST_BLUR : lwd_pkg::ST_IDLE;
      lwd_pkg::ST_BLUR:  state_next = lwd_pkg::ST_MUL;
      lwd_pkg::ST_MUL:   state_next = lwd_pkg::ST_RDIV;
      lwd_pkg::ST_RDIV:  state_next = lwd_pkg::ST_EMIT;
      lwd_pkg::ST_EMIT:  if (!m_valid || m_ready) state_next = lwd_pkg::ST_IDLE;
      default:           state_next = lwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.pop       = (state == lwd_pkg::ST_IDLE) && q_valid;
    ctrl.div_start = ((state == lwd_pkg::ST_IDLE) && q_valid)
                  || ((state == lwd_pkg::ST_GREY) && need);
    ctrl.mem_we    = (state == lwd_pkg::ST_CLEAR) || (state == lwd_pkg::ST_SHIFT);
    ctrl.clearing  = state == lwd_pkg::ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      mem[ctrl.clearing ? clr_addr : x] <= ctrl.clearing ? 16'd0 : {rd_data[7:0], v};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      items    <= '0;
      sent     <= '0;
      m_valid  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (state == lwd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ctrl.pop && (sent >= total)) begin
        items <= '0;
        sent  <= '0;
      end
      if (state == lwd_pkg::ST_SHIFT) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= rd_data[15:8];
        win[5] <= rd_data[7:0];
        win[8] <= v;
        items  <= n + NW'(1);
      end
      if (state == lwd_pkg::ST_EMIT && (!m_valid || m_ready)) begin
        m_valid <= 1'b1;
        if (kp1 >= total) begin
          items <= '0;
          sent  <= '0;
        end else begin
          sent <= kp1;
        end
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      n     <= n_sel;
      drain <= q_item.drain;
      num   <= q_item.num;
    end
    if (state == lwd_pkg::ST_DIVX && div_done) begin
      x       <= div_r[AW-1:0];
      rd_addr <= div_r[AW-1:0];
      qn      <= div_q;
    end
    if (state == lwd_pkg::ST_GREY) begin
      v <= '0;
    end
    if (state == lwd_pkg::ST_DIVG && div_done) begin
      v <= div_q[7:0];
    end
    if (state == lwd_pkg::ST_SHIFT) begin
      hl  <= cx != '0;
      hr  <= (WW'(cx) + WW'(1)) < width;
      hu  <= cyp > NW'(1);
      hd  <= cyp < NW'(height);
      kp1 <= n - NW'(width);
      last <= (n - NW'(width)) == total;
    end
    if (state == lwd_pkg::ST_BLUR) begin
      c    <= win[4];
      blur <= bsum[11:4];
      lapm <= lap_s[10] ? 10'(-lap_s) : lap_s[9:0];
    end
    if (state == lwd_pkg::ST_MUL) begin
      mag <= 18'(lapm) * 18'(dmag);
      sgn <= diff[8];
    end
    if (state == lwd_pkg::ST_RDIV) begin
      rq <= rprod[lwd_pkg::RECIP_SHIFT +: 8];
    end
    if (state == lwd_pkg::ST_EMIT && (!m_valid || m_ready)) begin
      m_pixel <= res;
      m_last  <= last;
    end
  end

endmodule

FILE: design/laplace_weighted_denoise_stream_top.sv
// Grey-scale Laplacian-weighted blur blend over a 3x3 window. RGB pixels come
// in raster order (tuser = 1 marks a drain item); the result for pixel k leaves
// with the item that is width+1 places later, so width+1 drain items flush a
// frame, and tlast marks the frame's last pixel. One bit-serial divider in the
// back end finds the column position of every item and, for an item that needs
// it, the grey weighting. A drain item, an item past the frame end or a zero
// weight sum skips the grey division. The blend scale uses a reciprocal
// multiply. A stalled output holds the back end until the pixel is taken. After
// reset a clearing pass zeroes all MAX_WIDTH line-buffer entries before the
// first item is taken. Write configuration only while the block is idle.
module laplace_weighted_denoise_stream_top #(
  parameter int MAX_WIDTH = lwd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lwd_pkg::IN_DATA_W-1:0] s_axis_tdata,  // red, green, blue
  input  logic                          s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lwd_pkg::PIX_W-1:0]     m_axis_tdata,  // pixel_out
  output logic                          m_axis_tlast,
  input  logic                          cfg_wen,
  input  logic [lwd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lwd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NW = WW + 17;
  localparam int CW = (WW > 11) ? WW : 11;

  logic [10:0]                      width_reg;
  logic [lwd_pkg::HEIGHT_W-1:0]     height_reg;
  logic [lwd_pkg::PIX_W-1:0]        wred, wgreen, wblue;
  logic [WW-1:0]                    weff;
  logic [lwd_pkg::HEIGHT_W-1:0]     heff;
  logic [NW-1:0]                    total;
  logic [lwd_pkg::WSUM_W-1:0]       wsum;
  lwd_pkg::ctrl_t                   ctrl;
  logic                             q_push, q_ready, q_valid;
  lwd_pkg::item_t                   q_wr, q_rd;

  always_comb begin
    if (width_reg == '0) begin
      weff = WW'(1);
    end else if (CW'(width_reg) > CW'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(width_reg);
    end
    heff = (height_reg == '0) ? lwd_pkg::HEIGHT_W'(1) : height_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd640;
      height_reg <= 16'd480;
      wred       <= 8'd77;
      wgreen     <= 8'd150;
      wblue      <= 8'd29;
    end else if (cfg_wen) begin
      case (lwd_pkg::reg_idx_t'(cfg_index))
        lwd_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
        lwd_pkg::REG_HEIGHT: height_reg <= cfg_data;
        lwd_pkg::REG_WRED:   wred       <= cfg_data[7:0];
        lwd_pkg::REG_WGREEN: wgreen     <= cfg_data[7:0];
        lwd_pkg::REG_WBLUE:  wblue      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total <= NW'(weff) * NW'(heff);
    wsum  <= lwd_pkg::WSUM_W'(wred) + lwd_pkg::WSUM_W'(wgreen) + lwd_pkg::WSUM_W'(wblue);
  end

  lwd_front u_front (
    .clk(clk), .rst(rst), .hold(ctrl.clearing),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .wred(wred), .wgreen(wgreen), .wblue(wblue),
    .q_ready(q_ready), .q_push(q_push), .q_item(q_wr)
  );

  lwd_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wr_item(q_wr), .ready(q_ready),
    .pop(ctrl.pop), .valid(q_valid), .rd_item(q_rd)
  );

  lwd_back #(.MAX_WIDTH(MAX_WIDTH), .WW(WW), .NW(NW)) u_back (
    .clk(clk), .rst(rst), .width(weff), .height(heff), .total(total), .wsum(wsum),
    .q_valid(q_valid), .q_item(q_rd), .ctrl(ctrl),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_pixel(m_axis_tdata), .m_last(m_axis_tlast)
  );

endmodule
